FILE: src/bsid_pkg.sv
`timescale 1ns / 1ps
package bsid_pkg;

  localparam int unsigned TableDepth = 16;

  localparam logic [3:0] ST_IDLE         = 4'd0;
  localparam logic [3:0] ST_START        = 4'd1;
  localparam logic [3:0] ST_REPEAT       = 4'd2;
  localparam logic [3:0] ST_WAIT         = 4'd3;
  localparam logic [3:0] ST_VERIFY       = 4'd4;
  localparam logic [3:0] ST_RESET_START  = 4'd5;
  localparam logic [3:0] ST_RESET_REPEAT = 4'd6;
  localparam logic [3:0] ST_RESET_WAIT   = 4'd7;
  localparam logic [3:0] ST_FINISH       = 4'd8;

  localparam logic [2:0] FRAME_NONE   = 3'd0;
  localparam logic [2:0] FRAME_QUERY  = 3'd1;
  localparam logic [2:0] FRAME_ASSIGN = 3'd2;
  localparam logic [2:0] FRAME_RESET  = 3'd3;
  localparam logic [2:0] FRAME_VERIFY = 3'd4;

  localparam logic [1:0] NOTE_NONE  = 2'd0;
  localparam logic [1:0] NOTE_SLAVE = 2'd1;
  localparam logic [1:0] NOTE_DONE  = 2'd2;

  localparam logic [7:0] BCAST = 8'hFF;

  localparam logic [2:0] REG_REFRESH = 3'd0;
  localparam logic [2:0] REG_WINDOW  = 3'd1;
  localparam logic [2:0] REG_GUARD   = 3'd2;
  localparam logic [2:0] REG_QUERY   = 3'd3;
  localparam logic [2:0] REG_VERIFY  = 3'd4;
  localparam logic [2:0] REG_RESET   = 3'd5;

  // table search command and status
  typedef struct packed {
    logic start;   // begin match/append of held serial
    logic clear;   // drop all entries
  } tbl_cmd_t;

  typedef struct packed {
    logic done;    // search finished this cycle
    logic stored;  // entry written
  } tbl_sts_t;

endpackage

FILE: src/bsid_table.sv
`timescale 1ns / 1ps
module bsid_table #(
  parameter int unsigned TABLE_DEPTH = bsid_pkg::TableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsid_pkg::tbl_cmd_t            cmd_i,
  input  logic [63:0]                   ser_lo_i,
  input  logic [31:0]                   ser_hi_i,
  input  logic [7:0]                    id_i,
  output bsid_pkg::tbl_sts_t            sts_o,
  output logic [3:0]                    index_o,
  output logic [4:0]                    count_o
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] lo_mem [TABLE_DEPTH];
  logic [31:0] hi_mem [TABLE_DEPTH];
  logic [7:0]  id_mem [TABLE_DEPTH];

  logic          busy_q, busy_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   rd_lo_q;
  logic [31:0]   rd_hi_q;
  logic          rd_v_q, rd_v_d;
  logic [CW-1:0] rd_ptr_q;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          hit;

  assign hit = rd_v_q && rd_lo_q == ser_lo_i && rd_hi_q == ser_hi_i;

  // Read one entry per cycle, compare the registered read next cycle.
  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    rd_v_d = 1'b0;
    wr_en  = 1'b0;
    wr_idx = '0;
    sts_o  = '0;
    index_o = '0;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end else if (busy_q) begin
      if (hit) begin
        wr_en  = 1'b1;
        wr_idx = rd_ptr_q[IW-1:0];
        busy_d = 1'b0;
        sts_o.done = 1'b1;
        sts_o.stored = 1'b1;
        index_o = 4'(rd_ptr_q);
      end else if (ptr_q < cnt_q) begin
        rd_v_d = 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end else if (!rd_v_q) begin
        busy_d = 1'b0;
        sts_o.done = 1'b1;
        if (cnt_q < CW'(TABLE_DEPTH)) begin
          wr_en  = 1'b1;
          wr_idx = cnt_q[IW-1:0];
          cnt_d  = cnt_q + 1'b1;
          sts_o.stored = 1'b1;
          index_o = 4'(cnt_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lo_mem[wr_idx] <= ser_lo_i;
      hi_mem[wr_idx] <= ser_hi_i;
      id_mem[wr_idx] <= id_i;
    end
    rd_lo_q  <= lo_mem[ptr_q[IW-1:0]];
    rd_hi_q  <= hi_mem[ptr_q[IW-1:0]];
    rd_ptr_q <= ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
      cnt_q  <= '0;
      rd_v_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      rd_v_q <= rd_v_d;
    end
  end

  assign count_o = 5'(cnt_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH)) else $error("table count overflow");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> !busy_q) else $error("table busy after done");
  a_stored_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.stored |-> sts_o.done) else $error("store without done");
endmodule

FILE: src/bsid_ctrl.sv
`timescale 1ns / 1ps
module bsid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [31:0]        now_ticks_i,
  input  logic               lock_granted_i,
  input  logic               send_ok_i,
  input  logic               recv_ok_i,
  input  logic [63:0]        serial_low_i,
  input  logic [31:0]        serial_high_i,
  input  logic [31:0]        refresh_period_i,
  input  logic [15:0]        window_time_i,
  input  logic [15:0]        window_guard_time_i,
  input  logic [7:0]         query_repeats_i,
  input  logic [7:0]         verify_repeats_i,
  input  logic [7:0]         reset_repeats_i,
  output bsid_pkg::tbl_cmd_t tcmd_o,
  output logic [63:0]        held_lo_o,
  output logic [31:0]        held_hi_o,
  output logic [7:0]         cur_id_o,
  input  bsid_pkg::tbl_sts_t tsts_i,
  input  logic [3:0]         tidx_i,
  input  logic [4:0]         tcount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         frame_kind_o,
  output logic [7:0]         target_address_o,
  output logic [7:0]         assigned_id_o,
  output logic [63:0]        out_serial_low_o,
  output logic [31:0]        out_serial_high_o,
  output logic [1:0]         notify_o,
  output logic [3:0]         entry_index_o,
  output logic               release_bus_o,
  output logic [3:0]         state_code_o,
  output logic [4:0]         table_count_o
);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_SRCH = 2'd1;
  localparam logic [1:0] P_OUT  = 2'd2;

  logic [1:0]  ph_q, ph_d;
  logic [3:0]  st_q, st_d;
  logic        rerun_q, rerun_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] rstart_q, rstart_d, wstart_q, wstart_d;
  logic [8:0]  qleft_q, qleft_d;
  logic [8:0]  vleft_q, vleft_d, rleft_q, rleft_d;
  logic        seen_q, seen_d;
  logic [63:0] hlo_q, hlo_d;
  logic [31:0] hhi_q, hhi_d;
  logic [2:0]  fr_q, fr_d;
  logic [7:0]  tg_q, tg_d, aid_q, aid_d;
  logic        osel_q, osel_d;
  logic [1:0]  nt_q, nt_d;
  logic [3:0]  ei_q, ei_d;
  logic        rel_q, rel_d;
  logic        clr;
  logic        srch;
  logic        acc;
  logic [31:0] wel, rel_el;
  logic [16:0] win_sum;
  logic [7:0]  nid;

  assign in_stall_o = ph_q != P_IDLE;
  assign acc = in_valid_i && ph_q == P_IDLE;
  assign wel = now_ticks_i - wstart_q;
  assign rel_el = now_ticks_i - rstart_q;
  assign win_sum = {1'b0, window_time_i} + {1'b0, window_guard_time_i};
  assign nid = (id_q == 8'hFF) ? 8'd1 : id_q + 8'd1;

  always_comb begin
    ph_d = ph_q; st_d = st_q; rerun_d = rerun_q; id_d = id_q;
    rstart_d = rstart_q; wstart_d = wstart_q; qleft_d = qleft_q;
    vleft_d = vleft_q; rleft_d = rleft_q; seen_d = seen_q;
    hlo_d = hlo_q; hhi_d = hhi_q;
    fr_d = fr_q; tg_d = tg_q; aid_d = aid_q; osel_d = osel_q;
    nt_d = nt_q; ei_d = ei_q; rel_d = rel_q;
    clr = 1'b0; srch = 1'b0;
    if (ph_q == P_OUT) begin
      if (!out_stall_i) ph_d = P_IDLE;
    end else if (ph_q == P_SRCH) begin
      if (tsts_i.done) begin
        if (tsts_i.stored) begin
          nt_d = bsid_pkg::NOTE_SLAVE;
          ei_d = tidx_i;
        end
        ph_d = P_OUT;
      end
    end else if (acc) begin
      ph_d = P_OUT;
      fr_d = bsid_pkg::FRAME_NONE; tg_d = '0; aid_d = '0; osel_d = 1'b0;
      nt_d = bsid_pkg::NOTE_NONE; ei_d = '0; rel_d = 1'b0;
      if (kind_i) begin
        rerun_d = 1'b1;
      end else begin
        case (st_q)
          bsid_pkg::ST_IDLE: begin
            if ((rerun_q || (refresh_period_i != '0 && rel_el >= refresh_period_i))
                && lock_granted_i) st_d = bsid_pkg::ST_RESET_START;
          end
          bsid_pkg::ST_START: begin
            id_d = '0; rerun_d = 1'b0; rstart_d = now_ticks_i;
            qleft_d = {1'b0, query_repeats_i};
            st_d = bsid_pkg::ST_REPEAT;
          end
          bsid_pkg::ST_REPEAT: begin
            if (qleft_q != '0) begin
              qleft_d = qleft_q - 1'b1;
              fr_d = bsid_pkg::FRAME_QUERY; tg_d = bsid_pkg::BCAST;
              if (send_ok_i) begin
                seen_d = 1'b0; wstart_d = now_ticks_i; st_d = bsid_pkg::ST_WAIT;
              end
            end else begin
              st_d = bsid_pkg::ST_FINISH;
            end
          end
          bsid_pkg::ST_WAIT: begin
            if (!seen_q && recv_ok_i) begin
              hlo_d = serial_low_i; hhi_d = serial_high_i;
              id_d = nid; seen_d = 1'b1;
            end
            if (wel >= {15'd0, win_sum}) begin
              st_d = bsid_pkg::ST_REPEAT;
              if (seen_d) begin
                fr_d = bsid_pkg::FRAME_ASSIGN; tg_d = bsid_pkg::BCAST;
                aid_d = id_d; osel_d = 1'b1;
                if (send_ok_i) begin
                  if (qleft_q < 9'd255) qleft_d = qleft_q + 1'b1;
                  vleft_d = {1'b0, verify_repeats_i};
                  st_d = bsid_pkg::ST_VERIFY;
                end
              end
            end
          end
          bsid_pkg::ST_VERIFY: begin
            if (vleft_q != '0) begin
              vleft_d = vleft_q - 1'b1;
              fr_d = bsid_pkg::FRAME_VERIFY; tg_d = id_q; aid_d = id_q;
              if (send_ok_i && recv_ok_i) begin
                vleft_d = '0; srch = 1'b1; ph_d = P_SRCH;
              end
            end else begin
              st_d = bsid_pkg::ST_REPEAT;
            end
          end
          bsid_pkg::ST_RESET_START: begin
            rleft_d = {1'b0, reset_repeats_i}; clr = 1'b1;
            st_d = bsid_pkg::ST_RESET_REPEAT;
          end
          bsid_pkg::ST_RESET_REPEAT: begin
            if (rleft_q != '0) begin
              rleft_d = rleft_q - 1'b1;
              fr_d = bsid_pkg::FRAME_RESET; tg_d = bsid_pkg::BCAST;
              if (send_ok_i) begin
                wstart_d = now_ticks_i; st_d = bsid_pkg::ST_RESET_WAIT;
              end
            end else begin
              st_d = bsid_pkg::ST_START;
            end
          end
          bsid_pkg::ST_RESET_WAIT: begin
            if (wel >= {15'd0, window_guard_time_i, 1'b0})
              st_d = bsid_pkg::ST_RESET_REPEAT;
          end
          bsid_pkg::ST_FINISH: begin
            rstart_d = now_ticks_i; st_d = bsid_pkg::ST_IDLE;
            nt_d = bsid_pkg::NOTE_DONE; rel_d = 1'b1;
          end
          default: st_d = bsid_pkg::ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE; st_q <= bsid_pkg::ST_IDLE; rerun_q <= 1'b1; id_q <= '0;
      rstart_q <= '0; wstart_q <= '0; qleft_q <= '0; vleft_q <= '0;
      rleft_q <= '0; seen_q <= 1'b0; hlo_q <= '0; hhi_q <= '0;
    end else begin
      ph_q <= ph_d; st_q <= st_d; rerun_q <= rerun_d; id_q <= id_d;
      rstart_q <= rstart_d; wstart_q <= wstart_d; qleft_q <= qleft_d;
      vleft_q <= vleft_d; rleft_q <= rleft_d; seen_q <= seen_d;
      hlo_q <= hlo_d; hhi_q <= hhi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d; tg_q <= tg_d; aid_q <= aid_d; osel_q <= osel_d;
    nt_q <= nt_d; ei_q <= ei_d; rel_q <= rel_d;
  end

  assign tcmd_o.start = srch;
  assign tcmd_o.clear = clr;
  assign held_lo_o = hlo_q;
  assign held_hi_o = hhi_q;
  assign cur_id_o = id_q;

  assign out_valid_o = ph_q == P_OUT;
  assign frame_kind_o = fr_q;
  assign target_address_o = tg_q;
  assign assigned_id_o = aid_q;
  assign out_serial_low_o = osel_q ? hlo_q : '0;
  assign out_serial_high_o = osel_q ? hhi_q : '0;
  assign notify_o = nt_q;
  assign entry_index_o = ei_q;
  assign release_bus_o = rel_q;
  assign state_code_o = st_q;
  assign table_count_o = tcount_i;

  a_srch_from_verify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch |-> st_q == bsid_pkg::ST_VERIFY) else $error("search outside verify");
  a_srch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == P_SRCH && tsts_i.done) |=> ph_q == P_OUT) else $error("search lost");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q != P_IDLE |-> in_stall_o) else $error("accept while busy");
  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && st_q == bsid_pkg::ST_WAIT && !seen_q && recv_ok_i && !kind_i)
      |=> id_q != 8'd0) else $error("id wrapped to zero");
endmodule

FILE: src/bus_slave_id_discovery_master.sv
`timescale 1ns / 1ps
// Each accepted item yields one registered result; a successful verify
//   read first runs a table search over the stored entries.
// Flow: in_stall_o holds new items until the previous result has left the output;
//   a verified slave is matched against the table (one entry compared per cycle).
// Reset: rst_ni asynchronous active low; sequencer idle, rerun pending,
//   table empty, registers at their documented defaults.
module bus_slave_id_discovery_master #(
  parameter int unsigned TABLE_DEPTH = bsid_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] now_ticks_i,
  input  logic        lock_granted_i,
  input  logic        send_ok_i,
  input  logic        recv_ok_i,
  input  logic [63:0] serial_low_i,
  input  logic [31:0] serial_high_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_kind_o,
  output logic [7:0]  target_address_o,
  output logic [7:0]  assigned_id_o,
  output logic [63:0] out_serial_low_o,
  output logic [31:0] out_serial_high_o,
  output logic [1:0]  notify_o,
  output logic [3:0]  entry_index_o,
  output logic        release_bus_o,
  output logic [3:0]  state_code_o,
  output logic [4:0]  table_count_o
);
  logic [31:0] refresh_q;
  logic [15:0] window_q, guard_q;
  logic [7:0]  qrep_q, vrep_q, rrep_q;
  logic        wr;
  logic [2:0]  ridx;

  bsid_pkg::tbl_cmd_t tcmd;
  bsid_pkg::tbl_sts_t tsts;
  logic [63:0] hlo;
  logic [31:0] hhi;
  logic [7:0]  cid;
  logic [3:0]  tidx;
  logic [4:0]  tcnt;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[4:2];

  // Configuration registers: write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= '0;
      window_q  <= 16'd100;
      guard_q   <= 16'd20;
      qrep_q    <= 8'd3;
      vrep_q    <= 8'd3;
      rrep_q    <= 8'd2;
    end else if (wr) begin
      case (ridx)
        bsid_pkg::REG_REFRESH: refresh_q <= pwdata;
        bsid_pkg::REG_WINDOW:  window_q  <= pwdata[15:0];
        bsid_pkg::REG_GUARD:   guard_q   <= pwdata[15:0];
        bsid_pkg::REG_QUERY:   qrep_q    <= pwdata[7:0];
        bsid_pkg::REG_VERIFY:  vrep_q    <= pwdata[7:0];
        bsid_pkg::REG_RESET:   rrep_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      bsid_pkg::REG_REFRESH: prdata = refresh_q;
      bsid_pkg::REG_WINDOW:  prdata = {16'd0, window_q};
      bsid_pkg::REG_GUARD:   prdata = {16'd0, guard_q};
      bsid_pkg::REG_QUERY:   prdata = {24'd0, qrep_q};
      bsid_pkg::REG_VERIFY:  prdata = {24'd0, vrep_q};
      bsid_pkg::REG_RESET:   prdata = {24'd0, rrep_q};
      default:               prdata = '0;
    endcase
  end

  // Sequencer: steps the discovery states, one item at a time.
  bsid_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .kind_i, .now_ticks_i, .lock_granted_i, .send_ok_i, .recv_ok_i,
    .serial_low_i, .serial_high_i,
    .refresh_period_i(refresh_q), .window_time_i(window_q),
    .window_guard_time_i(guard_q), .query_repeats_i(qrep_q),
    .verify_repeats_i(vrep_q), .reset_repeats_i(rrep_q),
    .tcmd_o(tcmd), .held_lo_o(hlo), .held_hi_o(hhi), .cur_id_o(cid),
    .tsts_i(tsts), .tidx_i(tidx), .tcount_i(tcnt),
    .out_valid_o, .out_stall_i, .frame_kind_o, .target_address_o,
    .assigned_id_o, .out_serial_low_o, .out_serial_high_o, .notify_o,
    .entry_index_o, .release_bus_o, .state_code_o, .table_count_o
  );

  // Slave table: serial search one entry per cycle, then update or, if not full, append.
  bsid_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i, .rst_ni, .cmd_i(tcmd), .ser_lo_i(hlo), .ser_hi_i(hhi),
    .id_i(cid), .sts_o(tsts), .index_o(tidx), .count_o(tcnt)
  );
endmodule
